[design/smt_pkg.sv]
// Shared types and constants for the submatrix transpose engine.
// Used by the top, front and back modules; depends on nothing.
package smt_pkg;

  localparam int WordW = 20;
  localparam int HashW = 50;

  // Generator and hash constants.
  localparam logic [WordW-1:0] GenMask  = 20'd987654;
  localparam logic [7:0]       GenMul   = 8'd197;
  localparam logic [WordW-1:0] GenAdd   = 20'd2017;
  localparam logic [7:0]       HashMul  = 8'd179;
  localparam logic [HashW-1:0] HashMask = 50'd987654321054321;

  // Configuration register indexes.
  localparam logic CfgDim  = 1'b0;
  localparam logic CfgSeed = 1'b1;

  typedef enum logic [1:0] {
    OP_FILL      = 2'd0,
    OP_TRANSPOSE = 2'd1,
    OP_HASH      = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  // Classified command as it travels from front to back.
  typedef struct packed {
    op_e        op;
    logic [5:0] row;
    logic [5:0] col;
    logic [6:0] side;
    logic       oob;
  } cmd_t;

  // Seed register update from the fill sequencer.
  typedef struct packed {
    logic             we;
    logic [WordW-1:0] val;
  } seed_upd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_HASH,
    ST_TR_BASE,
    ST_TR_PTR,
    ST_TR_RA,
    ST_TR_RB,
    ST_TR_WA,
    ST_TR_WB
  } back_state_e;

endpackage

[design/submatrix_transpose_engine.sv]
// Submatrix transpose engine: n by n matrix of 20-bit words with fill,
// in-place submatrix transpose and hash. A transpose swaps each pair by
// reading both words and then writing both back, an order set by the
// single read and single write port of the matrix RAM. One command
// at a time. After reset a clearing pass writes MAX_DIM*MAX_DIM zeros,
// one word a cycle, before the first command word is accepted.
module submatrix_transpose_engine #(
  parameter int MAX_DIM = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // op[1:0], row_start[7:2], col_start[13:8],
                                      // block_side[20:14], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // status[0], hash_value[50:1], zero pad
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [19:0] cfg_data_i
);
  import smt_pkg::*;

  localparam int NW = $clog2(MAX_DIM + 1);

  logic [6:0]       dim_q, dim_d;
  logic [WordW-1:0] seed_q, seed_d;
  logic [NW-1:0]    n_act;
  logic             cmd_valid, cmd_pop, clear_done;
  cmd_t             cmd;
  seed_upd_t        seed_upd;

  // Active side length, clamped to one and to MAX_DIM.
  always_comb begin
    if (dim_q == 7'd0) begin
      n_act = NW'(1);
    end else if (32'(dim_q) > MAX_DIM) begin
      n_act = NW'(MAX_DIM);
    end else begin
      n_act = NW'(dim_q);
    end
  end

  // Configuration registers; fill advances the seed.
  always_comb begin
    dim_d  = dim_q;
    seed_d = seed_q;
    if (seed_upd.we) begin
      seed_d = seed_upd.val;
    end
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDim:  dim_d  = cfg_data_i[6:0];
        CfgSeed: seed_d = cfg_data_i;
        default: dim_d  = dim_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q  <= 7'd64;
      seed_q <= '0;
    end else begin
      dim_q  <= dim_d;
      seed_q <= seed_d;
    end
  end

  smt_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .n_i           (n_act),
    .clear_done_i  (clear_done),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  smt_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .n_i           (n_act),
    .seed_i        (seed_q),
    .seed_upd_o    (seed_upd),
    .clear_done_o  (clear_done),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[design/smt_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module smt_ram #(
  parameter int Width = 20,
  parameter int Depth = 4096
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/smt_front.sv]
// Front end: accepts command words, checks transpose bounds and queues them.
// Depends on smt_pkg.
module smt_front #(
  parameter int MAX_DIM = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [23:0]                      s_axis_tdata,
  input  logic [$clog2(MAX_DIM+1)-1:0]     n_i,
  input  logic                             clear_done_i,
  output logic                             cmd_valid_o,
  output smt_pkg::cmd_t                    cmd_o,
  input  logic                             cmd_pop_i
);
  import smt_pkg::*;

  localparam int NW = $clog2(MAX_DIM + 1);
  localparam int SW = (NW + 1 > 8) ? NW + 1 : 8;

  cmd_t       ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_new;
  logic       push;
  logic [SW-1:0] row_end, col_end;

  // Decode the incoming word and check the submatrix against the matrix.
  always_comb begin
    row_end       = SW'(s_axis_tdata[7:2]) + SW'(s_axis_tdata[20:14]);
    col_end       = SW'(s_axis_tdata[13:8]) + SW'(s_axis_tdata[20:14]);
    cmd_new.op    = op_e'(s_axis_tdata[1:0]);
    cmd_new.row   = s_axis_tdata[7:2];
    cmd_new.col   = s_axis_tdata[13:8];
    cmd_new.side  = s_axis_tdata[20:14];
    cmd_new.oob   = (row_end > SW'(n_i)) || (col_end > SW'(n_i));
  end

  assign s_axis_tready = clear_done_i && (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (cnt_q != 2'd0);
  assign cmd_o         = ent_q[rd_ptr_q];

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ cmd_pop_i;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue entries.
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

[design/smt_back.sv]
// Back end: sequencer that clears, fills, hashes and transposes the store.
// Depends on smt_pkg and smt_ram.
module smt_back #(
  parameter int MAX_DIM = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  input  smt_pkg::cmd_t                    cmd_i,
  output logic                             cmd_pop_o,
  input  logic [$clog2(MAX_DIM+1)-1:0]     n_i,
  input  logic [smt_pkg::WordW-1:0]        seed_i,
  output smt_pkg::seed_upd_t               seed_upd_o,
  output logic                             clear_done_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [55:0]                      m_axis_tdata
);
  import smt_pkg::*;

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = $clog2(Depth + 1);

  back_state_e      state_q, state_d;
  logic [CW-1:0]    k_q, k_d;
  logic [CW-1:0]    count_q, count_d;
  logic             hv_q, hv_d;
  logic [HashW-1:0] h_q, h_d;
  cmd_t             cmd_q, cmd_d;
  logic [6:0]       i_q, i_d, j_q, j_d;
  logic [AW-1:0]    base_q, base_d, a_q, a_d, b_q, b_d;
  logic [WordW-1:0] tmp_q, tmp_d;
  logic             out_valid_q, out_valid_d;
  logic             out_status_q, out_status_d;
  logic [HashW-1:0] out_hash_q, out_hash_d;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [WordW-1:0] ram_wdata, ram_rdata;
  logic [HashW+7:0] h_prod;
  logic [WordW+7:0] seed_prod;

  smt_ram #(.Width(WordW), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next generator value and next hash value.
  assign seed_prod = (WordW+8)'(seed_i) * (WordW+8)'(GenMul) + (WordW+8)'(GenAdd);
  assign h_prod    = (HashW+8)'(h_q) * (HashW+8)'(HashMul) + (HashW+8)'(ram_rdata);

  assign clear_done_o  = (state_q != ST_CLEAR);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_hash_q, out_status_q};

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    count_d      = count_q;
    hv_d         = 1'b0;
    h_d          = h_q;
    cmd_d        = cmd_q;
    i_d          = i_q;
    j_d          = j_q;
    base_d       = base_q;
    a_d          = a_q;
    b_d          = b_q;
    tmp_d        = tmp_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_hash_d   = out_hash_q;
    cmd_pop_o    = 1'b0;
    seed_upd_o   = '0;
    ram_we       = 1'b0;
    ram_waddr    = k_q[AW-1:0];
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = k_q[AW-1:0];

    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        k_d    = k_q + 1'b1;
        if (k_q == CW'(Depth - 1)) begin
          k_d     = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          count_d   = CW'(n_i) * CW'(n_i);
          k_d       = '0;
          h_d       = '0;
          case (cmd_i.op)
            OP_FILL: state_d = ST_FILL;
            OP_HASH: state_d = ST_HASH;
            OP_TRANSPOSE: begin
              if (cmd_i.oob || cmd_i.side < 7'd2) begin
                out_valid_d  = 1'b1;
                out_status_d = cmd_i.oob;
                out_hash_d   = '0;
              end else begin
                state_d = ST_TR_BASE;
              end
            end
            default: begin
              out_valid_d  = 1'b1;
              out_status_d = 1'b0;
              out_hash_d   = '0;
            end
          endcase
        end
      end
      ST_FILL: begin
        if (k_q < count_q) begin
          ram_we         = 1'b1;
          ram_wdata      = seed_i;
          seed_upd_o.we  = 1'b1;
          seed_upd_o.val = seed_prod[WordW-1:0] & GenMask;
          k_d            = k_q + 1'b1;
        end else begin
          out_valid_d  = 1'b1;
          out_status_d = 1'b0;
          out_hash_d   = '0;
          state_d      = ST_IDLE;
        end
      end
      ST_HASH: begin
        // One read issued per cycle; its data folds into the hash in the cycle after.
        if (k_q < count_q) begin
          ram_re = 1'b1;
          hv_d   = 1'b1;
          k_d    = k_q + 1'b1;
        end
        if (hv_q) begin
          h_d = h_prod[HashW-1:0] & HashMask;
        end
        if (k_q == count_q && !hv_q) begin
          out_valid_d  = 1'b1;
          out_status_d = 1'b0;
          out_hash_d   = h_q;
          state_d      = ST_IDLE;
        end
      end
      ST_TR_BASE: begin
        base_d  = AW'(AW'(cmd_q.row) * AW'(n_i));
        state_d = ST_TR_PTR;
      end
      ST_TR_PTR: begin
        i_d     = 7'd0;
        j_d     = 7'd1;
        a_d     = base_q + AW'(cmd_q.col) + AW'(1);
        b_d     = base_q + AW'(n_i) + AW'(cmd_q.col);
        state_d = ST_TR_RA;
      end
      ST_TR_RA: begin
        ram_re    = 1'b1;
        ram_raddr = a_q;
        state_d   = ST_TR_RB;
      end
      ST_TR_RB: begin
        ram_re    = 1'b1;
        ram_raddr = b_q;
        tmp_d     = ram_rdata;
        state_d   = ST_TR_WA;
      end
      ST_TR_WA: begin
        ram_we    = 1'b1;
        ram_waddr = a_q;
        ram_wdata = ram_rdata;
        state_d   = ST_TR_WB;
      end
      ST_TR_WB: begin
        ram_we    = 1'b1;
        ram_waddr = b_q;
        ram_wdata = tmp_q;
        state_d   = ST_TR_RA;
        if (j_q == cmd_q.side - 7'd1) begin
          // End of a row of the upper triangle: step down one diagonal place.
          if (i_q + 7'd2 < cmd_q.side) begin
            i_d    = i_q + 7'd1;
            j_d    = i_q + 7'd2;
            base_d = base_q + AW'(n_i);
            a_d    = base_q + AW'(n_i) + AW'(cmd_q.col) + AW'(i_q) + AW'(2);
            b_d    = base_q + AW'(n_i) + AW'(n_i) + AW'(cmd_q.col) + AW'(i_q) + AW'(1);
          end else begin
            out_valid_d  = 1'b1;
            out_status_d = 1'b0;
            out_hash_d   = '0;
            state_d      = ST_IDLE;
          end
        end else begin
          j_d = j_q + 7'd1;
          a_d = a_q + AW'(1);
          b_d = b_q + AW'(n_i);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      k_q         <= '0;
      hv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      hv_q        <= hv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    count_q      <= count_d;
    h_q          <= h_d;
    cmd_q        <= cmd_d;
    i_q          <= i_d;
    j_q          <= j_d;
    base_q       <= base_d;
    a_q          <= a_d;
    b_q          <= b_d;
    tmp_q        <= tmp_d;
    out_status_q <= out_status_d;
    out_hash_q   <= out_hash_d;
  end

endmodule

[design/smt_checker.sv]
// Port-level checks for the submatrix transpose engine, bound to the top.
// No package dependencies.
module smt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  // A result word stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped before it was taken");

  // An ignored submatrix never carries a hash.
  a_status_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[50:1] == 50'd0)
    else $error("flagged result carries a nonzero hash");

  // Padding bits of the result word are zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[55:51] == 5'd0)
    else $error("result padding is not zero");

  // The clearing pass blocks input right after reset.
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready)
    else $error("input accepted before the store was cleared");

endmodule

bind submatrix_transpose_engine smt_checker u_smt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
